// ===== design/mppo_pkg.sv =====
// Shared constants and types for the perturb-and-observe power point tracker.
`timescale 1ns / 1ps
`default_nettype none

package mppo_pkg;

	localparam int DUTY_BITS_DEF  = 8;
	localparam int POWER_BITS_DEF = 16;

	// Configuration port geometry: two 8-bit registers.
	localparam int CFG_DATA_BITS  = 8;
	localparam int CFG_INDEX_BITS = 1;

	localparam int RESET_DUTY_STEP = 5;
	localparam int RESET_MAX_DUTY  = 255;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DUTY_STEP = 1'b0,
		REG_MAX_DUTY  = 1'b1
	} cfg_reg_t;

	// Kind of the next power sample.
	typedef enum logic [1:0] {
		PROBE_REF  = 2'd0,
		PROBE_LOW  = 2'd1,
		PROBE_HIGH = 2'd2
	} probe_t;

endpackage

`default_nettype wire

// ===== design/mppo_if.sv =====
// Valid/ready channel interfaces for power samples and duty results.
`timescale 1ns / 1ps
`default_nettype none

interface mppo_in_if #(
	parameter int POWER_BITS = mppo_pkg::POWER_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [POWER_BITS-1:0] power_sample;

	modport source (output valid, output action, output power_sample, input ready);
	modport sink (input valid, input action, input power_sample, output ready);
endinterface

interface mppo_out_if #(
	parameter int DUTY_BITS = mppo_pkg::DUTY_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic [DUTY_BITS-1:0] duty_request;
	logic                 calibrating;
	logic [1:0]           probe_phase;
	logic                 duty_moved;

	modport source (output valid, output duty_request, output calibrating,
		output probe_phase, output duty_moved, input ready);
	modport sink (input valid, input duty_request, input calibrating,
		input probe_phase, input duty_moved, output ready);
endinterface

`default_nettype wire

// ===== design/mppo_in_reg.sv =====
// Input register stage that holds one accepted sample beat.
`timescale 1ns / 1ps
`default_nettype none

module mppo_in_reg #(
	parameter int POWER_BITS = mppo_pkg::POWER_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	mppo_in_if.sink     up,
	mppo_in_if.source   dn
);
	import mppo_pkg::*;

	logic                  valid_s1;
	logic                  action_s1;
	logic [POWER_BITS-1:0] power_s1;

	// The stage refills in the same cycle that the downstream takes it.
	assign up.ready = !valid_s1 || dn.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up.ready) begin
			valid_s1 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up.valid && up.ready) begin
			action_s1 <= up.action;
			power_s1  <= up.power_sample;
		end
	end

	assign dn.valid        = valid_s1;
	assign dn.action       = action_s1;
	assign dn.power_sample = power_s1;

endmodule

`default_nettype wire

// ===== design/mppo_tracker.sv =====
// Tracker state, configuration registers, next-duty logic and result register.
`timescale 1ns / 1ps
`default_nettype none

module mppo_tracker #(
	parameter int DUTY_BITS  = mppo_pkg::DUTY_BITS_DEF,
	parameter int POWER_BITS = mppo_pkg::POWER_BITS_DEF
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      cfg_we,
	input  wire  [mppo_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  wire  [mppo_pkg::CFG_DATA_BITS-1:0]       cfg_wdata,
	mppo_in_if.sink                                  stg,
	mppo_out_if.source                               res
);
	import mppo_pkg::*;

	logic [DUTY_BITS-1:0]  duty_step_q;
	logic [DUTY_BITS-1:0]  max_duty_q;

	logic                  cal_q;
	probe_t                phase_q;
	logic [DUTY_BITS-1:0]  od_q;
	logic [POWER_BITS-1:0] ref_q;

	logic                  res_valid_q;
	logic [DUTY_BITS-1:0]  res_duty_q;
	logic                  res_cal_q;
	probe_t                res_phase_q;
	logic                  res_moved_q;

	logic                  load;
	probe_t                ph_eff;
	logic [DUTY_BITS-1:0]  duty_dn;
	logic [DUTY_BITS-1:0]  duty_upv;
	logic                  cal_d;
	probe_t                phase_d;
	logic [DUTY_BITS-1:0]  od_d;
	logic [POWER_BITS-1:0] ref_d;
	logic [DUTY_BITS-1:0]  req_d;
	logic                  higher;

	assign stg.ready = !res_valid_q || res.ready;
	assign load      = stg.valid && stg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_step_q <= DUTY_BITS'(RESET_DUTY_STEP);
			max_duty_q  <= DUTY_BITS'(RESET_MAX_DUTY);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DUTY_STEP: duty_step_q <= DUTY_BITS'(cfg_wdata);
				REG_MAX_DUTY:  max_duty_q  <= DUTY_BITS'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Saturating probe duties around the operating duty.
	always_comb begin
		duty_dn = (od_q > duty_step_q) ? (od_q - duty_step_q) : '0;
		if (od_q >= max_duty_q) begin
			duty_upv = max_duty_q;
		end else if ((max_duty_q - od_q) > duty_step_q) begin
			duty_upv = od_q + duty_step_q;
		end else begin
			duty_upv = max_duty_q;
		end
	end

	// An upper probe is meaningless during calibration and is read as a reference.
	always_comb begin
		case (phase_q)
			PROBE_LOW:  ph_eff = PROBE_LOW;
			PROBE_HIGH: ph_eff = cal_q ? PROBE_REF : PROBE_HIGH;
			default:    ph_eff = PROBE_REF;
		endcase
	end

	assign higher = stg.power_sample > ref_q;

	always_comb begin
		cal_d   = cal_q;
		phase_d = PROBE_REF;
		od_d    = od_q;
		ref_d   = ref_q;
		req_d   = od_q;
		if (stg.action) begin
			cal_d = 1'b1;
			od_d  = max_duty_q;
			req_d = max_duty_q;
		end else if (ph_eff == PROBE_REF) begin
			ref_d   = stg.power_sample;
			phase_d = PROBE_LOW;
			req_d   = duty_dn;
		end else if (cal_q) begin
			// Sweep down; stop once the lower duty gives less power or duty hits zero.
			od_d  = duty_dn;
			req_d = duty_dn;
			if ((ref_q > stg.power_sample) || (duty_dn == '0)) begin
				cal_d = 1'b0;
			end
		end else if (ph_eff == PROBE_LOW) begin
			if (higher) begin
				od_d  = duty_dn;
				req_d = duty_dn;
			end else begin
				phase_d = PROBE_HIGH;
				req_d   = duty_upv;
			end
		end else begin
			if (higher) begin
				od_d  = duty_upv;
				req_d = duty_upv;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q       <= 1'b1;
			phase_q     <= PROBE_REF;
			od_q        <= DUTY_BITS'(RESET_MAX_DUTY);
			ref_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cal_q   <= cal_d;
				phase_q <= phase_d;
				od_q    <= od_d;
				ref_q   <= ref_d;
			end
			if (stg.ready) begin
				res_valid_q <= stg.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_duty_q  <= req_d;
			res_cal_q   <= cal_d;
			res_phase_q <= phase_d;
			res_moved_q <= (od_d != od_q);
		end
	end

	assign res.valid        = res_valid_q;
	assign res.duty_request = res_duty_q;
	assign res.calibrating  = res_cal_q;
	assign res.probe_phase  = res_phase_q;
	assign res.duty_moved   = res_moved_q;

	// A restart beat always reports calibration at the maximum duty.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load && stg.action |=> res_cal_q && (res_duty_q == $past(max_duty_q)))
		else $error("restart did not return to calibration at max duty");

	// The moved flag reflects exactly a change of the operating duty.
	a_moved: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> res_moved_q == (od_q != $past(od_q)))
		else $error("duty_moved disagrees with operating duty update");

	// The reported calibration flag matches the state left behind.
	a_cal: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (res_cal_q == cal_q) && (res_phase_q == phase_q))
		else $error("result flags disagree with tracker state");

endmodule

`default_nettype wire

// ===== design/mppt_perturb_observe_unit.sv =====
// Top level of the perturb-and-observe maximum power point tracker.
// A sample beat passes through the input register stage and then the result register.
// Throughput: one beat per cycle while result_ch is not stalled; the next-duty decision
// is combinational, and all tracker state updates when the result register loads.
// Reset (arst_n low, asynchronous): calibration mode, reference phase, operating duty
// 255, reference power 0, duty step 5, max duty 255; both channel stages empty.
`timescale 1ns / 1ps
`default_nettype none

module mppt_perturb_observe_unit #(
	parameter int DUTY_BITS  = mppo_pkg::DUTY_BITS_DEF,
	parameter int POWER_BITS = mppo_pkg::POWER_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [mppo_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire  [mppo_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	mppo_in_if.sink                              sample_ch,
	mppo_out_if.source                           result_ch
);
	import mppo_pkg::*;

	// Each sample beat is either a power reading taken at the duty last requested,
	// or a restart command. The input register decouples the sample channel from
	// the tracker, so one more beat can be held while the tracker result waits downstream.
	mppo_in_if #(.POWER_BITS(POWER_BITS)) stage_ch ();

	mppo_in_reg #(
		.POWER_BITS (POWER_BITS)
	) u_in_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (sample_ch),
		.dn     (stage_ch)
	);

	// The tracker holds the configuration registers and the sweep/probe state.
	// Calibration walks down from the maximum duty one step per pair of samples;
	// tracking probes one step below, then above unless the lower probe won, and moves
	// toward the higher power. Every result beat carries the duty to apply next.
	mppo_tracker #(
		.DUTY_BITS  (DUTY_BITS),
		.POWER_BITS (POWER_BITS)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.stg       (stage_ch),
		.res       (result_ch)
	);

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the perturb-and-observe power point tracker: directed and random sample beats.
`timescale 1ns / 1ps

module tb;
	import mppo_pkg::*;

	localparam int DW = DUTY_BITS_DEF;
	localparam int PW = POWER_BITS_DEF;

	// Action codes of a sample beat.
	localparam bit SAMPLE  = 1'b0;
	localparam bit RESTART = 1'b1;

	// Phase code that the tracker never issues; it is treated as a reference sample.
	localparam logic [1:0] PHASE_UNUSED = 2'd3;

	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400_000;
	localparam int PRINT_CAP   = 40;

	typedef struct packed {
		logic [DW-1:0] duty;
		logic          calib;
		logic [1:0]    phase;
		logic          moved;
	} duty_beat_t;

	// Scoreboard: carries its own copy of the tracker state and register file, predicts
	// the duty beat caused by each accepted sample beat and compares result beats in order.
	class mppt_duty_scoreboard;
		logic [DW-1:0] step_reg;
		logic [DW-1:0] max_reg;
		bit            calib;
		logic [1:0]    phase;
		logic [DW-1:0] duty;
		logic [PW-1:0] ref_power;
		logic [DW-1:0] next_duty;
		duty_beat_t    expected_duties[$];
		int            errors;

		function new();
			step_reg  = DW'(RESET_DUTY_STEP);
			max_reg   = DW'(RESET_MAX_DUTY);
			calib     = 1'b1;
			phase     = PROBE_REF;
			duty      = DW'(RESET_MAX_DUTY);
			ref_power = '0;
			next_duty = duty;
			errors    = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [DW-1:0] val);
			case (idx)
				REG_DUTY_STEP: step_reg = val;
				REG_MAX_DUTY:  max_reg = val;
				default: ;
			endcase
		endfunction

		function logic [DW-1:0] lower(logic [DW-1:0] d);
			return (d > step_reg) ? d - step_reg : '0;
		endfunction

		function logic [DW-1:0] upper(logic [DW-1:0] d);
			if (d >= max_reg)
				return max_reg;
			return (max_reg - d > step_reg) ? d + step_reg : max_reg;
		endfunction

		function void note_sample(bit act, logic [PW-1:0] power);
			logic [DW-1:0] prior;
			logic [DW-1:0] req;
			prior = duty;
			if (phase == PHASE_UNUSED || (calib && phase == PROBE_HIGH))
				phase = PROBE_REF;
			if (act == RESTART) begin
				calib = 1'b1;
				phase = PROBE_REF;
				duty  = max_reg;
				req   = duty;
			end else if (phase == PROBE_REF) begin
				ref_power = power;
				phase     = PROBE_LOW;
				req       = lower(duty);
			end else if (calib) begin
				duty = lower(duty);
				if (ref_power > power || duty == 0)
					calib = 1'b0;
				phase = PROBE_REF;
				req   = duty;
			end else if (phase == PROBE_LOW) begin
				if (power > ref_power) begin
					duty  = lower(duty);
					phase = PROBE_REF;
					req   = duty;
				end else begin
					phase = PROBE_HIGH;
					req   = upper(duty);
				end
			end else begin
				if (power > ref_power)
					duty = upper(duty);
				phase = PROBE_REF;
				req   = duty;
			end
			next_duty = req;
			expected_duties.push_back('{req, calib, phase, duty != prior});
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_CAP)
				$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		task check_duty(duty_beat_t got);
			duty_beat_t want;
			if (expected_duties.size() == 0) begin
				report("result beat arrived with no sample beat outstanding");
				return;
			end
			want = expected_duties.pop_front();
			if (got.duty !== want.duty)
				report($sformatf("duty_request got %0d want %0d", got.duty, want.duty));
			if (got.calib !== want.calib)
				report($sformatf("calibrating got %0d want %0d", got.calib, want.calib));
			if (got.phase !== want.phase)
				report($sformatf("probe_phase got %0d want %0d", got.phase, want.phase));
			if (got.moved !== want.moved)
				report($sformatf("duty_moved got %0d want %0d", got.moved, want.moved));
		endtask

		task flag_leftovers();
			if (expected_duties.size() != 0)
				report($sformatf("%0d result beats never arrived", expected_duties.size()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	mppo_in_if  sample_if ();
	mppo_out_if result_if ();

	mppt_perturb_observe_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample_ch (sample_if),
		.result_ch (result_if)
	);

	mppt_duty_scoreboard sb;

	// Idle controls shared between the stimulus and the result receiver.
	int in_idle_pct  = 0;
	int out_idle_pct = 0;
	bit hold_req     = 1'b0;
	int cycle_count  = 0;

	// A synthetic panel: power falls off linearly on both sides of a peak duty, with
	// some noise and coarse quantization so that ties and false steps both happen.
	int curve_mpp;
	int curve_peak;
	int curve_slope;
	int curve_noise;
	int curve_quant;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The run is bounded so that a hung handshake still ends in a verdict.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Every result beat is compared against the oldest prediction. Values are read at
	// the edge before any nonblocking update of that edge lands.
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			sb.check_duty('{result_if.duty_request, result_if.calibrating,
				result_if.probe_phase, result_if.duty_moved});
	end

	// Result receiver. It stalls in random bursts, and once holds off for a long stretch
	// so that both stages of the block fill up and the sample channel backs up.
	initial begin
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_if.ready <= 1'b1;
			end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
				result_if.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				result_if.ready <= 1'b1;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// All driving tasks are entered at a rising edge and return at a rising edge.
	task automatic send_sample(bit act, logic [PW-1:0] power);
		sample_if.valid        <= 1'b1;
		sample_if.action       <= act;
		sample_if.power_sample <= power;
		do @(posedge clk); while (!sample_if.ready);
		// The prediction is made in this process so the next beat can aim at its duty.
		sb.note_sample(act, power);
	endtask

	task automatic sender_gap();
		if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
			sample_if.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// Registers may only change once every predicted duty beat has come out.
	task automatic wait_drained();
		while (sb.expected_duties.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [PW-1:0] panel_power(logic [DW-1:0] d);
		int span;
		int p;
		span = (int'(d) > curve_mpp) ? int'(d) - curve_mpp : curve_mpp - int'(d);
		p = curve_peak - curve_slope * span;
		if (p < 0)
			p = 0;
		p = p + $urandom_range(0, curve_noise);
		if (p > 65535)
			p = 65535;
		p = (p / curve_quant) * curve_quant;
		return PW'(p);
	endfunction

	// One configuration setting followed by a block of random beats. Most beats are
	// panel readings at the duty the tracker just asked for, so calibration ends and
	// tracking climbs toward the peak; the rest are exact ties with the reference,
	// arbitrary noise and the occasional recalibration.
	task automatic run_phase(logic [DW-1:0] step, logic [DW-1:0] maxd, int count,
		int in_pct, int out_pct, int hold_at);
		int k;
		int roll;
		logic [PW-1:0] pw;
		wait_drained();
		write_reg(REG_DUTY_STEP, step);
		write_reg(REG_MAX_DUTY, maxd);
		curve_mpp    = $urandom_range(0, maxd);
		curve_peak   = $urandom_range(2000, 65535);
		curve_slope  = $urandom_range(0, 600);
		curve_noise  = $urandom_range(0, 300);
		curve_quant  = $urandom_range(1, 64);
		in_idle_pct  = in_pct;
		out_idle_pct = out_pct;
		for (k = 0; k < count; k++) begin
			if (k == hold_at)
				hold_req = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 80)
				pw = panel_power(sb.next_duty);
			else if (roll < 90)
				pw = sb.ref_power;
			else
				pw = PW'($urandom);
			send_sample((roll < 3) ? RESTART : SAMPLE, pw);
			sender_gap();
		end
		sample_if.valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= REG_DUTY_STEP;
		cfg_wdata              <= '0;
		sample_if.valid        <= 1'b0;
		sample_if.action       <= SAMPLE;
		sample_if.power_sample <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Reset settings: the sweep starts at 255 and steps down by 5. A tie on the lower
		// duty keeps calibrating; only a drop ends the sweep, here at duty 240.
		send_sample(SAMPLE, 16'd100);
		send_sample(SAMPLE, 16'd200);
		send_sample(SAMPLE, 16'd200);
		send_sample(SAMPLE, 16'd200);
		send_sample(SAMPLE, 16'd300);
		send_sample(SAMPLE, 16'd0);
		// Tracking: lower probe wins, then ties on both probes, then the upper probe wins.
		send_sample(SAMPLE, 16'd0);
		send_sample(SAMPLE, 16'hFFFF);
		send_sample(SAMPLE, 16'hFFFF);
		send_sample(SAMPLE, 16'hFFFF);
		send_sample(SAMPLE, 16'hFFFF);
		send_sample(SAMPLE, 16'd1000);
		send_sample(SAMPLE, 16'd500);
		send_sample(SAMPLE, 16'd2000);
		// Recalibration ignores the power field, both from a reference and mid-probe.
		send_sample(RESTART, 16'hFFFF);
		send_sample(SAMPLE, 16'd10);
		send_sample(RESTART, 16'd0);
		sample_if.valid <= 1'b0;
		wait_drained();

		// A step of 255 drives the sweep straight to duty 0, which ends calibration;
		// the upper probe from 0 then saturates at the maximum duty.
		write_reg(REG_DUTY_STEP, 8'd255);
		write_reg(REG_MAX_DUTY, 8'd100);
		send_sample(SAMPLE, 16'd50);
		send_sample(SAMPLE, 16'd60);
		send_sample(SAMPLE, 16'd70);
		send_sample(SAMPLE, 16'd70);
		send_sample(SAMPLE, 16'd90);
		sample_if.valid <= 1'b0;
		wait_drained();

		// The limit drops below the operating duty, so the upper probe is the new limit.
		write_reg(REG_MAX_DUTY, 8'd40);
		send_sample(SAMPLE, 16'd5);
		send_sample(SAMPLE, 16'd1);
		send_sample(SAMPLE, 16'd9);
		sample_if.valid <= 1'b0;
		wait_drained();

		// With a zero step the probes sit on the operating duty and nothing moves.
		write_reg(REG_DUTY_STEP, 8'd0);
		send_sample(RESTART, 16'd0);
		send_sample(SAMPLE, 16'd5);
		send_sample(SAMPLE, 16'd5);
		sample_if.valid <= 1'b0;

		// Random phases: register extremes, random settings and a zero limit, then a tail
		// with no idling on either side. The long receiver hold-off falls in the first phase.
		run_phase(8'd5, 8'd255, 150, 20, 20, 60);
		run_phase(8'd1, 8'd255, 150, 30, 10, -1);
		run_phase(8'd255, 8'd255, 100, 10, 30, -1);
		run_phase(8'd0, 8'd255, 100, 15, 15, -1);
		run_phase(8'd1, 8'd1, 100, 25, 5, -1);
		run_phase(8'd255, 8'd1, 80, 5, 25, -1);
		repeat (3)
			run_phase(DW'($urandom_range(1, 40)), DW'($urandom_range(2, 255)), 120, 15, 15, -1);
		run_phase(8'd3, 8'd0, 40, 10, 10, -1);
		run_phase(DW'($urandom_range(1, 255)), 8'd255, 150, 0, 0, -1);

		wait_drained();
		repeat (6) @(posedge clk);
		sb.flag_leftovers();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
